/* rtl/core/tbp_pkg.sv */
// shared types and constants for the traffic burst packetizer
`default_nettype none

package tbp_pkg;

    localparam int MAX_PACKETS = 64;
    localparam int CNT_W       = 6;
    localparam int TIME_W      = 48;
    localparam int LEN_W       = 16;
    localparam int BYTES_W     = LEN_W + CNT_W;
    localparam int DELAY_W     = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [LEN_W-1:0] PACKET_BYTES_RST = 16'd1434;
    localparam logic [LEN_W-1:0] TOLERANCE_RST    = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE       = 2'd0,
        CFG_PACKET_BYTES = 2'd1,
        CFG_TOLERANCE    = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_CELL  = 1'b1
    } in_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             enable;
        logic [LEN_W-1:0] packet_bytes;
        logic [LEN_W-1:0] time_tolerance_us;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic advance;
    } dp_cmd_t;

    typedef struct packed {
        logic commit;
        logic last;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/traffic_burst_packetizer.sv */
// Traffic burst packetizer: merges cell events of one stream into bursts and
// emits each committed burst as a run of signed packet delay observations.
// Every input word is accepted in ST_IDLE and then evaluated in ST_EVAL. A word that
// commits a buffer is followed by its run of n observations, one per cycle
// while m_ready is high, with n up to 64.
// The run length comes from a repeated subtraction of packet_bytes from the
// buffered byte count in the emitter, one observation per cycle with m_ready high. No new
// input word is taken until the run has been delivered. Configuration is
// taken at any time but must only be written while the block is idle.
`default_nettype none

module traffic_burst_packetizer (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [tbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [tbp_pkg::LEN_W-1:0]     cfg_data,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire                           s_command,
    input  wire  [tbp_pkg::TIME_W-1:0]    s_time_us,
    input  wire  [tbp_pkg::LEN_W-1:0]     s_byte_count,
    input  wire                           s_direction,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic signed [tbp_pkg::DELAY_W-1:0] m_delay_code,
    output logic                          m_last_packet
);
    import tbp_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    tbp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tbp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tbp_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .cmd           (cmd),
        .status        (status),
        .s_command     (s_command),
        .s_time_us     (s_time_us),
        .s_byte_count  (s_byte_count),
        .s_direction   (s_direction),
        .m_delay_code  (m_delay_code),
        .m_last_packet (m_last_packet)
    );

endmodule

`default_nettype wire

/* rtl/core/tbp_cfg.sv */
// configuration registers of the traffic burst packetizer
`default_nettype none

module tbp_cfg (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [tbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [tbp_pkg::LEN_W-1:0]     cfg_data,
    output tbp_pkg::cfg_t                 cfg
);
    import tbp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_ENABLE:       cfg_next.enable            = cfg_data[0];
                CFG_PACKET_BYTES: cfg_next.packet_bytes      = cfg_data;
                CFG_TOLERANCE:    cfg_next.time_tolerance_us = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable            <= 1'b0;
            cfg_reg.packet_bytes      <= PACKET_BYTES_RST;
            cfg_reg.time_tolerance_us <= TOLERANCE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tbp_ctrl.sv */
// controller state machine of the traffic burst packetizer
`default_nettype none

module tbp_ctrl (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire                   m_ready,
    input  tbp_pkg::dp_status_t   status,
    output tbp_pkg::dp_cmd_t      cmd
);
    import tbp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = status.commit ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (m_ready && status.last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd.capture = 1'b0;
        cmd.eval    = 1'b0;
        cmd.advance = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
            end
            ST_EMIT: begin
                m_valid     = 1'b1;
                cmd.advance = m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tbp_datapath.sv */
// buffer state, merge and commit logic and run emitter of the packetizer
`default_nettype none

module tbp_datapath (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  tbp_pkg::cfg_t                cfg,
    input  tbp_pkg::dp_cmd_t             cmd,
    output tbp_pkg::dp_status_t          status,
    input  wire                          s_command,
    input  wire  [tbp_pkg::TIME_W-1:0]   s_time_us,
    input  wire  [tbp_pkg::LEN_W-1:0]    s_byte_count,
    input  wire                          s_direction,
    output logic signed [tbp_pkg::DELAY_W-1:0] m_delay_code,
    output logic                         m_last_packet
);
    import tbp_pkg::*;

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_PACKETS - 1);

    function automatic logic [DELAY_W-1:0] code_delay(input logic [TIME_W-1:0] d,
                                                      input logic dir);
        logic [DELAY_W-1:0] ext;
        ext = DELAY_W'(d);
        if (dir == 1'b0) begin
            code_delay = (d == '0) ? {1'b1, {(DELAY_W-1){1'b0}}} : (~ext + 1'b1);
        end else begin
            code_delay = (d == '0) ? {1'b0, {(DELAY_W-1){1'b1}}} : ext;
        end
    endfunction

    // latched input word
    logic               cmd_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               dir_reg;

    // buffer state
    logic [TIME_W-1:0]  prev_reg,   prev_next;
    logic [TIME_W-1:0]  start_reg,  start_next;
    logic [TIME_W-1:0]  delay_reg,  delay_next;
    logic [BYTES_W-1:0] bytes_reg,  bytes_next;
    logic               bdir_reg,   bdir_next;

    // run emitter
    logic [BYTES_W-1:0] rem_reg,    rem_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [DELAY_W-1:0] enc_reg,    enc_next;
    logic               rdir_reg,   rdir_next;

    logic [LEN_W-1:0]   pb_eff;
    logic [BYTES_W-1:0] cap;
    logic [TIME_W-1:0]  d_start;
    logic [TIME_W-1:0]  d_prev;
    logic               late;
    logic               commit;
    logic [BYTES_W-1:0] base;
    logic [BYTES_W:0]   sum;

    assign pb_eff  = (cfg.packet_bytes == '0) ? LEN_W'(1) : cfg.packet_bytes;
    assign cap     = BYTES_W'(pb_eff) * BYTES_W'(MAX_PACKETS);
    assign d_start = time_reg - start_reg;
    assign d_prev  = time_reg - prev_reg;
    assign late    = (time_reg >= start_reg) && (d_start >= TIME_W'(cfg.time_tolerance_us));
    assign commit  = cfg.enable && (cmd_reg == CMD_CELL) && (bytes_reg != '0)
                     && (late || (bdir_reg != dir_reg));
    assign base    = commit ? '0 : bytes_reg;
    assign sum     = {1'b0, base} + (BYTES_W+1)'(len_reg);

    assign status.commit = commit;
    assign status.last   = (rem_reg <= BYTES_W'(pb_eff)) || (cnt_reg == LAST_CNT);

    assign m_delay_code  = enc_reg;
    assign m_last_packet = status.last;

    always_comb begin
        prev_next  = prev_reg;
        start_next = start_reg;
        delay_next = delay_reg;
        bytes_next = bytes_reg;
        bdir_next  = bdir_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        enc_next   = enc_reg;
        rdir_next  = rdir_reg;

        if (cmd.eval && cfg.enable) begin
            if (cmd_reg == CMD_START) begin
                prev_next  = time_reg;
                start_next = '0;
                delay_next = '0;
                bytes_next = '0;
                bdir_next  = 1'b0;
            end else begin
                if (commit) begin
                    prev_next  = start_reg;
                    rem_next   = bytes_reg;
                    cnt_next   = '0;
                    enc_next   = code_delay(delay_reg, bdir_reg);
                    rdir_next  = bdir_reg;
                    start_next = '0;
                    delay_next = '0;
                    bytes_next = '0;
                    bdir_next  = 1'b0;
                end
                if (len_reg != '0) begin
                    if (base == '0) begin
                        bdir_next  = dir_reg;
                        start_next = time_reg;
                        // gap measured against the start of the burst just committed when there was one
                        if (commit) begin
                            delay_next = (time_reg >= start_reg) ? d_start : '0;
                        end else begin
                            delay_next = (time_reg >= prev_reg) ? d_prev : '0;
                        end
                    end
                    bytes_next = (sum > {1'b0, cap}) ? cap : sum[BYTES_W-1:0];
                end
            end
        end

        if (cmd.advance) begin
            rem_next = rem_reg - BYTES_W'(pb_eff);
            cnt_next = cnt_reg + 1'b1;
            enc_next = code_delay('0, rdir_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg  <= s_command;
            time_reg <= s_time_us;
            len_reg  <= s_byte_count;
            dir_reg  <= s_direction;
        end
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        enc_reg  <= enc_next;
        rdir_reg <= rdir_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= '0;
            start_reg <= '0;
            delay_reg <= '0;
            bytes_reg <= '0;
            bdir_reg  <= 1'b0;
        end else begin
            prev_reg  <= prev_next;
            start_reg <= start_next;
            delay_reg <= delay_next;
            bytes_reg <= bytes_next;
            bdir_reg  <= bdir_next;
        end
    end

endmodule

`default_nettype wire

/* dv/tb_traffic_burst_packetizer.sv */
// self-checking testbench for the traffic burst packetizer: random cells and streams, scoreboard
`timescale 1ns / 1ps

module tb_traffic_burst_packetizer;
    import tbp_pkg::*;

    localparam int                DRAIN_CYCLES = 100;
    localparam int                STALL_LIMIT  = 3000;
    localparam int                HOLD_CYCLES  = 300;
    localparam int                HOLD_AFTER   = 150;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic signed [DELAY_W-1:0] DELAY_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic signed [DELAY_W-1:0] DELAY_MIN = 64'h8000_0000_0000_0000;
    localparam logic [TIME_W-1:0] TIME_TOP = 48'hffff_ffff_ffff;

    typedef struct packed {
        in_cmd_t           cmd;
        logic [TIME_W-1:0] t;
        logic [LEN_W-1:0]  len;
        logic              dir;
    } cell_t;

    typedef struct packed {
        logic signed [DELAY_W-1:0] delay;
        logic                      last;
    } obs_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    wire                  s_command;
    wire  [TIME_W-1:0]    s_time_us;
    wire  [LEN_W-1:0]     s_byte_count;
    wire                  s_direction;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic signed [DELAY_W-1:0] m_delay_code;
    logic                 m_last_packet;

    cell_t drv_cell = '0;
    assign s_command    = drv_cell.cmd;
    assign s_time_us    = drv_cell.t;
    assign s_byte_count = drv_cell.len;
    assign s_direction  = drv_cell.dir;

    traffic_burst_packetizer u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_time_us     (s_time_us),
        .s_byte_count  (s_byte_count),
        .s_direction   (s_direction),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_delay_code  (m_delay_code),
        .m_last_packet (m_last_packet)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    cell_t cell_q[$];
    obs_t  obs_q[$];
    int    n_queued   = 0;
    int    n_accepted = 0;
    int    err_count  = 0;
    bit    calm       = 1'b0;
    bit    s_took     = 1'b0;
    logic [TIME_W-1:0] trace_t = '0;

    // predictor copy of configuration and burst state
    logic              obs_en  = 1'b0;
    logic [LEN_W-1:0]  obs_pkt = PACKET_BYTES_RST;
    logic [LEN_W-1:0]  obs_tol = TOLERANCE_RST;
    logic [TIME_W-1:0] prev_commit = '0;
    logic [TIME_W-1:0] burst_start = '0;
    logic [TIME_W-1:0] burst_gap   = '0;
    logic [31:0]       burst_bytes = '0;
    logic              burst_dir   = 1'b0;

    function automatic logic signed [DELAY_W-1:0] sign_delay(input logic [TIME_W-1:0] d,
                                                             input logic dir);
        if (d == 0) return dir ? DELAY_MAX : DELAY_MIN;
        return dir ? {16'd0, d} : 64'd0 - {16'd0, d};
    endfunction

    function automatic void clear_burst();
        burst_bytes = '0;
        burst_start = '0;
        burst_gap   = '0;
        burst_dir   = 1'b0;
    endfunction

    task automatic predict_obs(input cell_t c);
        logic [31:0] pb;
        logic [31:0] n;
        logic [31:0] cap;
        logic        late;
        obs_t        o;
        if (!obs_en) return;
        if (c.cmd == CMD_START) begin
            prev_commit = c.t;
            clear_burst();
            return;
        end
        pb = (obs_pkt == 0) ? 32'd1 : {16'd0, obs_pkt};
        if (burst_bytes > 0) begin
            late = (c.t >= burst_start) && ((c.t - burst_start) >= obs_tol);
            if (late || burst_dir != c.dir) begin
                n = (burst_bytes + pb - 1) / pb;
                if (n > MAX_PACKETS) n = MAX_PACKETS;
                for (int k = 0; k < n; k++) begin
                    o.delay = sign_delay((k == 0) ? burst_gap : '0, burst_dir);
                    o.last  = (k + 1 == n);
                    obs_q.push_back(o);
                end
                prev_commit = burst_start;
                clear_burst();
            end
        end
        if (c.len > 0) begin
            if (burst_bytes == 0) begin
                burst_dir   = c.dir;
                burst_start = c.t;
                burst_gap   = (c.t >= prev_commit) ? c.t - prev_commit : '0;
            end
            cap = MAX_PACKETS * pb;
            burst_bytes = burst_bytes + c.len;
            if (burst_bytes > cap) burst_bytes = cap;
        end
    endtask

    task automatic push_cell(input in_cmd_t cmd, input logic [TIME_W-1:0] t,
                             input logic [LEN_W-1:0] len, input logic dir);
        cell_q.push_back(cell_t'{cmd: cmd, t: t, len: len, dir: dir});
        n_queued++;
    endtask

    // mostly well-formed streams, some backward cells and random noise
    task automatic make_traffic(input int count);
        int                r;
        int                up;
        int                pb;
        logic [TIME_W-1:0] step;
        logic              dir;
        dir = 1'($urandom_range(0, 1));
        pb  = (obs_pkt == 0) ? 1 : obs_pkt;
        up  = (pb * 3 > 65535) ? 65535 : pb * 3;
        push_cell(CMD_START, trace_t, 16'($urandom), 1'($urandom_range(0, 1)));
        for (int i = 1; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                if (r < 2) trace_t = TIME_W'({$urandom, $urandom});
                push_cell(CMD_START, trace_t, 16'($urandom), 1'($urandom_range(0, 1)));
            end else if (r < 10) begin
                push_cell(in_cmd_t'($urandom_range(0, 1)), TIME_W'({$urandom, $urandom}),
                          16'($urandom), 1'($urandom_range(0, 1)));
            end else if (r < 14) begin
                push_cell(CMD_CELL, trace_t - TIME_W'($urandom_range(0, 300)),
                          16'($urandom_range(1, up)), dir);
            end else begin
                if ($urandom_range(0, 1)) step = TIME_W'($urandom_range(0, obs_tol));
                else step = TIME_W'(obs_tol) + TIME_W'($urandom_range(0, 2000));
                trace_t = trace_t + step;
                if ($urandom_range(0, 3) == 0) dir = !dir;
                r = $urandom_range(0, 9);
                push_cell(CMD_CELL, trace_t,
                          (r == 0) ? 16'd0 : (r < 8) ? 16'($urandom_range(1, up)) : 16'($urandom),
                          dir);
            end
        end
    endtask

    task automatic settle();
        while (n_accepted != n_queued || obs_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ENABLE:       obs_en  = val[0];
            CFG_PACKET_BYTES: obs_pkt = val;
            CFG_TOLERANCE:    obs_tol = val;
            default:          ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // input driver
    int src_gap   = 0;
    bit src_noisy = 1'b1;

    always @(negedge aclk) begin : drv
        logic  v;
        cell_t nxt;
        v   = s_valid;
        nxt = drv_cell;
        if (!aresetn) begin
            v = 1'b0;
        end else begin
            if (s_took) v = 1'b0;
            if (!v) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (!calm && src_noisy && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(0, 14);
                end else if (cell_q.size() != 0) begin
                    nxt = cell_q.pop_front();
                    v   = 1'b1;
                end
            end
            if ($urandom_range(0, 63) == 0) src_noisy = !src_noisy;
        end
        s_valid  <= v;
        drv_cell <= nxt;
    end

    // result receiver
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    int sink_gap   = 0;
    bit sink_noisy = 1'b1;

    always @(negedge aclk) begin : rcv
        logic r;
        if (!aresetn) begin
            r = 1'b0;
        end else if (hold_left > 0) begin
            r = 1'b0;
            hold_left--;
        end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
            r         = 1'b0;
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
        end else if (sink_gap > 0) begin
            r = 1'b0;
            sink_gap--;
        end else if (!calm && sink_noisy && $urandom_range(0, 5) == 0) begin
            r        = 1'b0;
            sink_gap = $urandom_range(0, 14);
        end else begin
            r = 1'b1;
        end
        if ($urandom_range(0, 63) == 0) sink_noisy = !sink_noisy;
        m_ready <= r;
    end

    // monitor and scoreboard
    always @(posedge aclk) begin : mon
        obs_t want;
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                predict_obs(cell_t'{cmd: in_cmd_t'(s_command), t: s_time_us, len: s_byte_count,
                                    dir: s_direction});
                n_accepted <= n_accepted + 1;
            end
            if (m_valid && m_ready) begin
                if (obs_q.size() == 0) begin
                    $error("delay_code: no word expected, actual %0d", m_delay_code);
                    err_count++;
                end else begin
                    want = obs_q.pop_front();
                    if (m_delay_code !== want.delay) begin
                        $error("delay_code: expected %0d, actual %0d", want.delay,
                               m_delay_code);
                        err_count++;
                    end
                    if (m_last_packet !== want.last) begin
                        $error("last_packet: expected %0b, actual %0b", want.last,
                               m_last_packet);
                        err_count++;
                    end
                end
            end
        end
    end

    int stuck = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
            if (stuck >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // disabled after reset: everything ignored
        push_cell(CMD_START, 48'd0, 16'd0, 1'b0);
        push_cell(CMD_CELL, 48'd10, 16'd100, 1'b1);
        push_cell(CMD_CELL, 48'd500, 16'd5, 1'b0);
        push_cell(CMD_CELL, 48'd900, 16'd0, 1'b1);
        settle();

        // directed cases on the reset packet size and tolerance
        write_reg(CFG_ENABLE, 16'd1);
        push_cell(CMD_START, 48'd1000, 16'd0, 1'b0);
        push_cell(CMD_CELL, 48'd1000, 16'd1, 1'b1);
        push_cell(CMD_CELL, 48'd1050, 16'd1434, 1'b1);
        push_cell(CMD_CELL, 48'd1050, 16'd0, 1'b0);
        push_cell(CMD_CELL, 48'd2000, 16'hffff, 1'b0);
        push_cell(CMD_CELL, 48'd2010, 16'hffff, 1'b0);
        push_cell(CMD_CELL, 48'd5000, 16'd10, 1'b0);
        push_cell(CMD_CELL, 48'd4000, 16'd5, 1'b0);
        push_cell(CMD_CELL, 48'd6000, 16'd7, 1'b1);
        push_cell(CMD_START, 48'd100, 16'hffff, 1'b1);
        push_cell(CMD_CELL, 48'd50, 16'd3, 1'b0);
        push_cell(CMD_CELL, 48'd200, 16'd3, 1'b0);
        push_cell(CMD_CELL, 48'd299, 16'd2, 1'b0);
        push_cell(CMD_CELL, 48'd300, 16'd1, 1'b0);
        push_cell(CMD_START, 48'd0, 16'd0, 1'b0);
        push_cell(CMD_CELL, TIME_TOP, 16'd1, 1'b0);
        push_cell(CMD_CELL, 48'd0, 16'hffff, 1'b0);
        push_cell(CMD_CELL, TIME_TOP, 16'd0, 1'b1);
        push_cell(CMD_START, TIME_TOP, 16'd0, 1'b1);
        push_cell(CMD_CELL, TIME_TOP, 16'hffff, 1'b1);
        push_cell(CMD_CELL, TIME_TOP, 16'hffff, 1'b1);
        push_cell(CMD_CELL, TIME_TOP, 16'd0, 1'b0);
        settle();

        write_reg(CFG_PACKET_BYTES, 16'hffff);
        write_reg(CFG_TOLERANCE, 16'hffff);
        make_traffic(80);
        settle();

        // packet size shrinks with bytes still buffered
        write_reg(CFG_PACKET_BYTES, 16'd1);
        write_reg(CFG_TOLERANCE, 16'd0);
        make_traffic(60);
        settle();

        write_reg(CFG_SPARE, 16'($urandom));
        write_reg(CFG_PACKET_BYTES, 16'd0);
        write_reg(CFG_TOLERANCE, 16'd1);
        make_traffic(40);
        settle();

        write_reg(CFG_ENABLE, 16'd0);
        make_traffic(20);
        settle();
        write_reg(CFG_ENABLE, 16'd1);

        repeat (4) begin
            write_reg(CFG_PACKET_BYTES, ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                        16'($urandom_range(1, 3000)));
            write_reg(CFG_TOLERANCE, $urandom_range(0, 1) ? 16'($urandom_range(0, 500)) :
                                     16'($urandom));
            make_traffic(60);
            settle();
        end

        calm = 1'b1;
        write_reg(CFG_PACKET_BYTES, 16'($urandom_range(1, 2000)));
        write_reg(CFG_TOLERANCE, 16'($urandom_range(0, 300)));
        make_traffic(60);
        settle();

        if (err_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/tbp_pkg.sv
rtl/core/tbp_cfg.sv
rtl/core/tbp_ctrl.sv
rtl/core/tbp_datapath.sv
rtl/core/traffic_burst_packetizer.sv
dv/tb_traffic_burst_packetizer.sv
